// ----- src/array_linked_list_engine_top_defines.svh -----
// assertion macros used by the checker file
`ifndef ARRAY_LINKED_LIST_ENGINE_TOP_DEFINES_SVH
`define ARRAY_LINKED_LIST_ENGINE_TOP_DEFINES_SVH

// checked only out of reset
`define ALLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every edge, reset included
`define ALLE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- src/alle_pkg.sv -----
// types and codes of the array linked list engine
`default_nettype none

package alle_pkg;

  typedef struct packed {
    logic [2:0]         mode;
    logic [7:0]         slot_index;
    logic signed [31:0] element;
  } alle_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         affected_slot;
    logic [7:0]         next_link;
    logic [7:0]         prev_link;
    logic signed [31:0] data_value;
  } alle_out_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_BAD   = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_EMPTY = 2'd3
  } alle_status_t;

  typedef enum logic [2:0] {
    MODE_INS_AFTER = 3'd0,
    MODE_DELETE    = 3'd1,
    MODE_INS_HEAD  = 3'd2,
    MODE_INS_TAIL  = 3'd3,
    MODE_DEL_HEAD  = 3'd4,
    MODE_DEL_TAIL  = 3'd5,
    MODE_QUERY     = 3'd6
  } alle_mode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_INS_FREE,
    S_INS_LINK,
    S_DEL_FREE
  } alle_state_t;

  typedef struct packed {
    logic clear_done;
    logic fail;
    logic is_ins;
    logic is_del;
  } alle_flags_t;

  typedef struct packed {
    logic busy;
    logic load;
    logic clear;
    logic check;
    logic ins_free;
    logic ins_link;
    logic del_free;
    logic emit;
  } alle_ctrl_t;

endpackage

`default_nettype wire

// ----- src/alle_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module alle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- src/alle_fsm.sv -----
// operation sequencer of the array linked list engine
`default_nettype none

module alle_fsm (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  alle_pkg::alle_flags_t flags,
  output alle_pkg::alle_ctrl_t  ctrl
);

  import alle_pkg::*;

  alle_state_t state_r;
  alle_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (flags.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: state_nxt = S_CHECK;
      S_CHECK: begin
        if (flags.fail) begin
          state_nxt = S_IDLE;
        end else if (flags.is_ins) begin
          state_nxt = S_INS_FREE;
        end else if (flags.is_del) begin
          state_nxt = S_DEL_FREE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_INS_FREE: state_nxt = S_INS_LINK;
      S_INS_LINK: state_nxt = S_IDLE;
      S_DEL_FREE: state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      S_CLEAR: begin
        ctrl.busy  = 1'b1;
        ctrl.clear = 1'b1;
      end
      S_IDLE: begin
        ctrl.load = start;
      end
      S_LOOKUP: begin
        ctrl.busy = 1'b1;
      end
      S_CHECK: begin
        ctrl.busy  = 1'b1;
        ctrl.check = 1'b1;
        ctrl.emit  = flags.fail || !(flags.is_ins || flags.is_del);
      end
      S_INS_FREE: begin
        ctrl.busy     = 1'b1;
        ctrl.ins_free = 1'b1;
      end
      S_INS_LINK: begin
        ctrl.busy     = 1'b1;
        ctrl.ins_link = 1'b1;
        ctrl.emit     = 1'b1;
      end
      S_DEL_FREE: begin
        ctrl.busy     = 1'b1;
        ctrl.del_free = 1'b1;
        ctrl.emit     = 1'b1;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/array_linked_list_engine_top.sv -----
// after acceptance an item passes lookup and check; delete adds a free state, insert a free and a link state
// a new item can be taken in the cycle the result is shown
// the sequence is set by the dependent reads and writes on the single write port link memories
// after reset a clearing pass over all SLOT_COUNT + 1 slots rebuilds the free chain, busy high
// results are strobed for one cycle on out_valid; the receiver cannot stall
`default_nettype none

module array_linked_list_engine_top #(
  parameter int SLOT_COUNT = 255,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  alle_pkg::alle_in_t in_item,
  output logic               out_valid,
  output alle_pkg::alle_out_t out_item
);

  import alle_pkg::*;

  localparam int Depth = SLOT_COUNT + 1;
  localparam int AW    = $clog2(Depth);

  alle_ctrl_t  ctrl;
  alle_flags_t flags;

  logic [2:0]            mode_r;
  logic [AW-1:0]         tgt_r;
  logic                  in_range_r;
  logic [DATA_WIDTH-1:0] elem_r;
  logic [AW-1:0]         fresh_r;
  logic [AW-1:0]         after_r;
  logic [AW-1:0]         free_head_r;
  logic [AW-1:0]         head_r;
  logic [AW-1:0]         tail_r;
  logic [AW-1:0]         clr_cnt_r;
  logic                  out_valid_r;
  alle_out_t             out_item_r;

  logic [AW-1:0]         tgt_nxt;
  logic                  in_range_nxt;
  logic [1:0]            code;
  logic                  used_ok;
  logic                  del_link;
  alle_out_t             res;

  logic                  data_we, next_we, prev_we, used_we;
  logic [AW-1:0]         data_waddr, next_waddr, prev_waddr, used_waddr;
  logic [DATA_WIDTH-1:0] data_wdata;
  logic [AW-1:0]         next_wdata, prev_wdata;
  logic                  used_wdata;
  logic [AW-1:0]         next_raddr;
  logic [DATA_WIDTH-1:0] data_q;
  logic [AW-1:0]         next_q, prev_q;
  logic                  used_q;

  alle_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .ctrl  (ctrl)
  );

  alle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(Depth)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (tgt_r),
    .rdata (data_q)
  );

  alle_ram #(.WIDTH(AW), .DEPTH(Depth)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (next_raddr),
    .rdata (next_q)
  );

  alle_ram #(.WIDTH(AW), .DEPTH(Depth)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (tgt_r),
    .rdata (prev_q)
  );

  alle_ram #(.WIDTH(1), .DEPTH(Depth)) u_used_ram (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .raddr (tgt_r),
    .rdata (used_q)
  );

  // target slot of the item
  always_comb begin
    tgt_nxt      = AW'(in_item.slot_index);
    in_range_nxt = ({24'd0, in_item.slot_index} <= 32'(SLOT_COUNT));
    case (in_item.mode)
      MODE_INS_HEAD: begin
        tgt_nxt      = '0;
        in_range_nxt = 1'b1;
      end
      MODE_INS_TAIL, MODE_DEL_TAIL: begin
        tgt_nxt      = tail_r;
        in_range_nxt = 1'b1;
      end
      MODE_DEL_HEAD: begin
        tgt_nxt      = head_r;
        in_range_nxt = 1'b1;
      end
      default: begin
        tgt_nxt      = AW'(in_item.slot_index);
        in_range_nxt = ({24'd0, in_item.slot_index} <= 32'(SLOT_COUNT));
      end
    endcase
  end

  // status decision
  always_comb begin
    used_ok      = in_range_r && used_q;
    flags        = '0;
    code         = STATUS_BAD;
    flags.is_ins = mode_r inside {MODE_INS_AFTER, MODE_INS_HEAD, MODE_INS_TAIL};
    flags.is_del = mode_r inside {MODE_DELETE, MODE_DEL_HEAD, MODE_DEL_TAIL};
    case (mode_r)
      MODE_INS_AFTER, MODE_INS_HEAD, MODE_INS_TAIL: begin
        if (!used_ok) begin
          code = STATUS_BAD;
        end else if (free_head_r == '0) begin
          code = STATUS_FULL;
        end else begin
          code = STATUS_OK;
        end
      end
      MODE_DELETE: begin
        code = (tgt_r == '0 || !used_ok) ? STATUS_BAD : STATUS_OK;
      end
      MODE_DEL_HEAD, MODE_DEL_TAIL: begin
        if (tgt_r == '0) begin
          code = STATUS_EMPTY;
        end else if (!used_ok) begin
          code = STATUS_BAD;
        end else begin
          code = STATUS_OK;
        end
      end
      MODE_QUERY: begin
        code = used_ok ? STATUS_OK : STATUS_BAD;
      end
      default: begin
        code = STATUS_BAD;
      end
    endcase
    flags.fail       = (code != STATUS_OK);
    flags.clear_done = (clr_cnt_r == AW'(SLOT_COUNT));
  end

  assign del_link   = ctrl.check && flags.is_del && !flags.fail;
  assign next_raddr = ctrl.check ? free_head_r : tgt_r;

  // memory writes
  always_comb begin
    data_we    = 1'b0;
    next_we    = 1'b0;
    prev_we    = 1'b0;
    used_we    = 1'b0;
    data_waddr = tgt_r;
    next_waddr = tgt_r;
    prev_waddr = tgt_r;
    used_waddr = tgt_r;
    data_wdata = '0;
    next_wdata = '0;
    prev_wdata = '0;
    used_wdata = 1'b0;
    if (ctrl.clear) begin
      data_we    = 1'b1;
      next_we    = 1'b1;
      prev_we    = 1'b1;
      used_we    = 1'b1;
      data_waddr = clr_cnt_r;
      next_waddr = clr_cnt_r;
      prev_waddr = clr_cnt_r;
      used_waddr = clr_cnt_r;
      next_wdata = (clr_cnt_r == '0 || clr_cnt_r == AW'(SLOT_COUNT)) ?
                   '0 : clr_cnt_r + AW'(1);
      used_wdata = (clr_cnt_r == '0);
    end else if (del_link) begin
      next_we    = 1'b1;
      next_waddr = prev_q;
      next_wdata = next_q;
      prev_we    = 1'b1;
      prev_waddr = next_q;
      prev_wdata = prev_q;
    end else if (ctrl.ins_free) begin
      next_we    = 1'b1;
      next_waddr = fresh_r;
      next_wdata = after_r;
      prev_we    = 1'b1;
      prev_waddr = fresh_r;
      prev_wdata = tgt_r;
      data_we    = 1'b1;
      data_waddr = fresh_r;
      data_wdata = elem_r;
      used_we    = 1'b1;
      used_waddr = fresh_r;
      used_wdata = 1'b1;
    end else if (ctrl.ins_link) begin
      prev_we    = 1'b1;
      prev_waddr = after_r;
      prev_wdata = fresh_r;
      next_we    = 1'b1;
      next_waddr = tgt_r;
      next_wdata = fresh_r;
    end else if (ctrl.del_free) begin
      data_we    = 1'b1;
      next_we    = 1'b1;
      next_wdata = free_head_r;
      prev_we    = 1'b1;
      used_we    = 1'b1;
    end
  end

  // result item
  always_comb begin
    res        = '0;
    res.status = STATUS_OK;
    if (ctrl.check) begin
      res.status = code;
      if (!flags.fail) begin
        res.affected_slot = 8'(tgt_r);
        res.next_link     = 8'(next_q);
        res.prev_link     = 8'(prev_q);
        res.data_value    = 32'(signed'(data_q));
      end
    end else if (ctrl.ins_link) begin
      res.affected_slot = 8'(fresh_r);
      res.next_link     = 8'(after_r);
      res.prev_link     = 8'(tgt_r);
      res.data_value    = 32'(signed'(elem_r));
    end else if (ctrl.del_free) begin
      res.affected_slot = 8'(tgt_r);
      res.next_link     = 8'(free_head_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      free_head_r <= AW'(1);
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.clear && !flags.clear_done) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (ctrl.ins_free) begin
        free_head_r <= next_q;
      end else if (ctrl.del_free) begin
        free_head_r <= tgt_r;
      end
      // sentinel links mirrored for head and tail
      if (next_we && next_waddr == '0) begin
        head_r <= next_wdata;
      end
      if (prev_we && prev_waddr == '0) begin
        tail_r <= prev_wdata;
      end
      out_valid_r <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mode_r     <= in_item.mode;
      tgt_r      <= tgt_nxt;
      in_range_r <= in_range_nxt;
      elem_r     <= DATA_WIDTH'(in_item.element);
    end
    if (ctrl.check) begin
      fresh_r <= free_head_r;
      after_r <= next_q;
    end
    if (ctrl.emit) begin
      out_item_r <= res;
    end
  end

  assign busy      = ctrl.busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ----- src/alle_chk.sv -----
// port checker of the array linked list engine, bound to the top level
`default_nettype none
`include "array_linked_list_engine_top_defines.svh"

module alle_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input alle_pkg::alle_out_t out_item
);

  import alle_pkg::*;

  logic err_res;
  logic pay_zero;

  assign err_res  = out_valid && (out_item.status != STATUS_OK);
  assign pay_zero = (out_item.affected_slot == 8'd0) && (out_item.next_link == 8'd0) &&
                    (out_item.prev_link == 8'd0) && (out_item.data_value == 32'sd0);

  `ALLE_ASSERT_ALWAYS(a_reset_busy, !rst_n |=> busy && !out_valid, "not busy after reset")

  `ALLE_ASSERT(a_accept_busy, (start && !busy) |=> busy, "item accepted but busy low")

  `ALLE_ASSERT(a_result_end, out_valid |-> (!busy && $past(busy)), "result not at end of item")

  `ALLE_ASSERT(a_error_zero, err_res |-> pay_zero, "error result with payload")

endmodule

bind array_linked_list_engine_top alle_chk u_alle_chk (.*);

`default_nettype wire
